/* hw/rtl/lcmf_pkg.sv */
// Shared types and constants of the lidar circle mask filter.
// Holds register indexes, item codes, hit codes and the angle table for the rotator.
`default_nettype none
package lcmf_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_SELF_RADIUS  = 3'd0;
  localparam logic [2:0] REG_OTHER_RADIUS = 3'd1;
  localparam logic [2:0] REG_RANGE_MAX    = 3'd2;
  localparam logic [2:0] REG_ANGLE_START  = 3'd3;
  localparam logic [2:0] REG_ANGLE_STEP   = 3'd4;
  localparam logic [2:0] REG_OTHERS_USE   = 3'd5;
  localparam logic [2:0] REG_STRICT       = 3'd6;

  // Item kinds. The spare code is ignored by the block.
  localparam logic [1:0] FUNC_START  = 2'd0;
  localparam logic [1:0] FUNC_LOAD   = 2'd1;
  localparam logic [1:0] FUNC_SAMPLE = 2'd2;
  localparam logic [1:0] FUNC_SPARE  = 2'd3;

  // Hit kinds.
  localparam logic [1:0] HIT_NONE  = 2'd0;
  localparam logic [1:0] HIT_SELF  = 2'd1;
  localparam logic [1:0] HIT_ROBOT = 2'd2;

  localparam int CORDIC_ITERS = 16;
  localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;

  typedef logic signed [32:0] cordic_t;
  typedef logic signed [23:0] mul_op_t;

  function automatic cordic_t cordic_atan(input logic [3:0] i);
    cordic_t v;
    unique case (i)
      4'd0:  v = 33'sd536870912;
      4'd1:  v = 33'sd316933406;
      4'd2:  v = 33'sd167458907;
      4'd3:  v = 33'sd85004756;
      4'd4:  v = 33'sd42667331;
      4'd5:  v = 33'sd21354465;
      4'd6:  v = 33'sd10679838;
      4'd7:  v = 33'sd5340245;
      4'd8:  v = 33'sd2670163;
      4'd9:  v = 33'sd1335087;
      4'd10: v = 33'sd667544;
      4'd11: v = 33'sd333772;
      4'd12: v = 33'sd166886;
      4'd13: v = 33'sd83443;
      4'd14: v = 33'sd41722;
      default: v = 33'sd20861;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/lidar_circle_mask_filter.sv */
// Top level of the lidar circle mask filter: sequencer, shared multiplier, CORDIC rotator.
// Depends on lcmf_pkg.
`default_nettype none
// Masks lidar range samples that fall on the own body or on other robots. An input item
// with tuser 0 starts a scan and forgets all robot positions, tuser 1 loads one robot
// position into a slot, tuser 2 is a range sample. Start and load items give no result.
// A finite sample is worked through one shared 24 by 24 multiplier and one shift-add
// rotator: ST_ANG and ST_ROUND form the beam angle, 16 CORDIC iterations in ST_COR give
// sine and cosine, ST_Q15, ST_PX, ST_PY and ST_PYW form the point, and each circle test
// then runs ST_SQX, ST_SQY, ST_RR and ST_CMP on the multiplier (self circle first, then
// every slot in use); the search ends early at the first hit. Non-finite samples go straight
// to the output stage. In strict mode a sample gives no result unless every slot in use
// is loaded. The block accepts no item while a sample is being worked on; one finished
// result waits in the output register while the next item is taken. Configuration may
// be written only while the block is idle.
module lidar_circle_mask_filter
  import lcmf_pkg::*;
#(
  parameter int OTHER_SLOTS     = 7,
  parameter int INDEX_BITS      = 12,
  parameter int TRIG_TABLE_BITS = 10
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [2:0]            cfg_index_i,
  input  wire logic [15:0]           cfg_data_i,
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // slot, pos_x_mm, pos_y_mm, sample_index, range_mm, range_finite, zero fill
  input  wire logic [((52+INDEX_BITS+7)/8)*8-1:0] s_axis_tdata_i,
  // func
  input  wire logic [1:0]            s_axis_tuser_i,
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  // out_index, out_range_mm, out_finite, zero fill
  output logic [((17+INDEX_BITS+7)/8)*8-1:0] m_axis_tdata_o,
  // hit_kind
  output logic [1:0]                 m_axis_tuser_o
);

  localparam int OUT_W  = ((17+INDEX_BITS+7)/8)*8;
  localparam int SLOT_W = (OTHER_SLOTS > 1) ? $clog2(OTHER_SLOTS) : 1;
  localparam int CW     = 7;
  localparam logic [15:0] ANG_HALF = 16'(1 << (15 - TRIG_TABLE_BITS));
  localparam logic [15:0] ANG_MASK = ~16'((1 << (16 - TRIG_TABLE_BITS)) - 1);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_ANG   = 4'd1;
  localparam logic [3:0] ST_ROUND = 4'd2;
  localparam logic [3:0] ST_COR   = 4'd3;
  localparam logic [3:0] ST_Q15   = 4'd4;
  localparam logic [3:0] ST_PX    = 4'd5;
  localparam logic [3:0] ST_PY    = 4'd6;
  localparam logic [3:0] ST_PYW   = 4'd7;
  localparam logic [3:0] ST_SQX   = 4'd8;
  localparam logic [3:0] ST_SQY   = 4'd9;
  localparam logic [3:0] ST_RR    = 4'd10;
  localparam logic [3:0] ST_CMP   = 4'd11;
  localparam logic [3:0] ST_DONE  = 4'd12;

  // Input fields.
  logic [2:0]            in_slot;
  logic signed [15:0]    in_x, in_y;
  logic [INDEX_BITS-1:0] in_idx;
  logic [15:0]           in_range;
  logic                  in_finite;
  assign in_slot   = s_axis_tdata_i[2:0];
  assign in_x      = s_axis_tdata_i[18:3];
  assign in_y      = s_axis_tdata_i[34:19];
  assign in_idx    = s_axis_tdata_i[35+INDEX_BITS-1:35];
  assign in_range  = s_axis_tdata_i[51+INDEX_BITS-1:35+INDEX_BITS];
  assign in_finite = s_axis_tdata_i[51+INDEX_BITS];

  // Configuration registers.
  logic [15:0] self_r_q, other_r_q, start_q;
  logic [14:0] rmax_q, step_q;
  logic [2:0]  ouse_q;
  logic        strict_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      self_r_q  <= 16'd200;
      other_r_q <= 16'd600;
      rmax_q    <= 15'd10000;
      start_q   <= 16'd0;
      step_q    <= 15'd0;
      ouse_q    <= 3'd1;
      strict_q  <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_SELF_RADIUS:  self_r_q  <= cfg_data_i;
        REG_OTHER_RADIUS: other_r_q <= cfg_data_i;
        REG_RANGE_MAX:    rmax_q    <= cfg_data_i[14:0];
        REG_ANGLE_START:  start_q   <= cfg_data_i;
        REG_ANGLE_STEP:   step_q    <= cfg_data_i[14:0];
        REG_OTHERS_USE:   ouse_q    <= cfg_data_i[2:0];
        REG_STRICT:       strict_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Robot position store; an entry's verdict counts only when its loaded bit is set.
  logic signed [15:0] rob_x_q [OTHER_SLOTS];
  logic signed [15:0] rob_y_q [OTHER_SLOTS];
  logic [OTHER_SLOTS-1:0] loaded_q, loaded_d;

  // Sequencer and datapath registers.
  logic [3:0]            state_q, state_d;
  logic [3:0]            iter_q, iter_d;
  logic [SLOT_W-1:0]     k_q, k_d;
  logic                  tself_q, tself_d;
  logic                  flip_q, flip_d;
  cordic_t               cx_q, cx_d, cy_q, cy_d, cz_q, cz_d;
  logic signed [15:0]    cos_q, cos_d, sin_q, sin_d;
  logic signed [23:0]    px_q, px_d, py_q, py_d;
  logic signed [47:0]    prod_q, prod_d;
  logic signed [47:0]    acc_q, acc_d;
  logic [INDEX_BITS-1:0] idx_q, idx_d;
  logic [15:0]           range_q, range_d;
  logic                  fin_q, fin_d;
  logic [1:0]            hit_q, hit_d;
  logic                  ov_q, ov_d;
  logic [INDEX_BITS-1:0] o_idx_q, o_idx_d;
  logic [15:0]           o_range_q, o_range_d;
  logic                  o_fin_q, o_fin_d;
  logic [1:0]            o_hit_q, o_hit_d;

  // Slots in use, saturated, and the strict-mode readiness test.
  logic [CW-1:0] used;
  logic          all_loaded;
  always_comb begin
    used = (CW'(ouse_q) > CW'(OTHER_SLOTS)) ? CW'(OTHER_SLOTS) : CW'(ouse_q);
    all_loaded = 1'b1;
    for (int k = 0; k < OTHER_SLOTS; k++) begin
      if (CW'(k) < used && !loaded_q[k]) all_loaded = 1'b0;
    end
  end

  // Shared multiplier.
  mul_op_t mul_a, mul_b;
  assign prod_d = mul_a * mul_b;

  // Current circle target.
  logic signed [23:0] tgt_x, tgt_y, dx, dy;
  logic [19:0]        rr;
  always_comb begin
    if (tself_q) begin
      tgt_x = '0;
      tgt_y = '0;
      rr    = {self_r_q, 4'd0};
    end else begin
      tgt_x = {{4{rob_x_q[k_q][15]}}, rob_x_q[k_q], 4'd0};
      tgt_y = {{4{rob_y_q[k_q][15]}}, rob_y_q[k_q], 4'd0};
      rr    = {other_r_q, 4'd0};
    end
    dx = px_q - tgt_x;
    dy = py_q - tgt_y;
  end

  // Rounded point coordinate from the product: floor((p + 1024) / 2048).
  logic signed [47:0] prod_rnd;
  assign prod_rnd = (prod_q + 48'sd1024) >>> 11;

  // CORDIC step and Q1.15 conversion.
  cordic_t xs, ys, atn;
  logic signed [33:0] xf, yf, xr, yr;
  logic [15:0] ang_w, ang_q16;
  logic [31:0] p_ang;
  assign xs  = cx_q >>> iter_q;
  assign ys  = cy_q >>> iter_q;
  assign atn = cordic_atan(iter_q);
  assign xf  = flip_q ? -34'(cx_q) : 34'(cx_q);
  assign yf  = flip_q ? -34'(cy_q) : 34'(cy_q);
  assign xr  = (xf + 34'sd16384) >>> 15;
  assign yr  = (yf + 34'sd16384) >>> 15;
  assign ang_w   = start_q + prod_q[15:0];
  assign ang_q16 = (ang_w + ANG_HALF) & ANG_MASK;
  assign p_ang   = {ang_q16 ^ {(ang_q16[15] ^ ang_q16[14]), 15'd0}, 16'd0};

  function automatic logic signed [15:0] clamp15(input logic signed [33:0] v);
    logic signed [15:0] r;
    if (v > 34'sd32767) r = 16'sd32767;
    else if (v < -34'sd32767) r = -16'sd32767;
    else r = v[15:0];
    return r;
  endfunction

  logic out_free;
  assign out_free = !ov_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;  iter_d = iter_q;  k_d = k_q;  tself_d = tself_q;
    flip_d = flip_q;  cx_d = cx_q;  cy_d = cy_q;  cz_d = cz_q;
    cos_d = cos_q;  sin_d = sin_q;  px_d = px_q;  py_d = py_q;  acc_d = acc_q;
    idx_d = idx_q;  range_d = range_q;  fin_d = fin_q;  hit_d = hit_q;
    loaded_d = loaded_q;
    ov_d = ov_q && !m_axis_tready_i;
    o_idx_d = o_idx_q;  o_range_d = o_range_q;  o_fin_d = o_fin_q;  o_hit_d = o_hit_q;
    mul_a = '0;  mul_b = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          idx_d   = in_idx;
          range_d = in_range;
          fin_d   = in_finite;
          hit_d   = HIT_NONE;
          unique case (s_axis_tuser_i)
            FUNC_START: loaded_d = '0;
            FUNC_LOAD: begin
              if (32'(in_slot) < OTHER_SLOTS) loaded_d[SLOT_W'(in_slot)] = 1'b1;
            end
            FUNC_SAMPLE: begin
              if (!strict_q || all_loaded) state_d = in_finite ? ST_ANG : ST_DONE;
            end
            default: ;
          endcase
        end
      end
      ST_ANG: begin
        mul_a   = mul_op_t'(idx_q);
        mul_b   = mul_op_t'(step_q);
        state_d = ST_ROUND;
      end
      ST_ROUND: begin
        flip_d  = ang_q16[15] ^ ang_q16[14];
        cx_d    = CORDIC_GAIN;
        cy_d    = '0;
        cz_d    = {p_ang[31], p_ang};
        iter_d  = '0;
        state_d = ST_COR;
      end
      ST_COR: begin
        if (!cz_q[32]) begin
          cx_d = cx_q - ys;  cy_d = cy_q + xs;  cz_d = cz_q - atn;
        end else begin
          cx_d = cx_q + ys;  cy_d = cy_q - xs;  cz_d = cz_q + atn;
        end
        iter_d = iter_q + 4'd1;
        if (iter_q == 4'(CORDIC_ITERS - 1)) state_d = ST_Q15;
      end
      ST_Q15: begin
        cos_d   = clamp15(xr);
        sin_d   = clamp15(yr);
        state_d = ST_PX;
      end
      ST_PX: begin
        mul_a   = mul_op_t'(range_q);
        mul_b   = mul_op_t'(cos_q);
        state_d = ST_PY;
      end
      ST_PY: begin
        px_d    = prod_rnd[23:0];
        mul_a   = mul_op_t'(range_q);
        mul_b   = mul_op_t'(sin_q);
        state_d = ST_PYW;
      end
      ST_PYW: begin
        py_d    = prod_rnd[23:0];
        tself_d = 1'b1;
        k_d     = '0;
        state_d = ST_SQX;
      end
      ST_SQX: begin
        mul_a   = dx;
        mul_b   = dx;
        state_d = ST_SQY;
      end
      ST_SQY: begin
        acc_d   = prod_q;
        mul_a   = dy;
        mul_b   = dy;
        state_d = ST_RR;
      end
      ST_RR: begin
        acc_d   = acc_q + prod_q;
        mul_a   = mul_op_t'(rr);
        mul_b   = mul_op_t'(rr);
        state_d = ST_CMP;
      end
      ST_CMP: begin
        // A slot that is not loaded is run through the unit but its verdict is dropped.
        if (acc_q <= prod_q && (tself_q || loaded_q[k_q])) begin
          hit_d   = tself_q ? HIT_SELF : HIT_ROBOT;
          state_d = ST_DONE;
        end else if (tself_q) begin
          tself_d = 1'b0;
          state_d = (used == '0) ? ST_DONE : ST_SQX;
        end else if (CW'(k_q) + CW'(1) >= used) begin
          state_d = ST_DONE;
        end else begin
          k_d     = k_q + SLOT_W'(1);
          state_d = ST_SQX;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          ov_d      = 1'b1;
          o_idx_d   = idx_q;
          o_fin_d   = fin_q;
          o_hit_d   = hit_q;
          o_range_d = (hit_q != HIT_NONE) ? {rmax_q, 1'b0} : range_q;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      loaded_q <= '0;
      ov_q     <= 1'b0;
      iter_q   <= '0;
      k_q      <= '0;
      tself_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      loaded_q <= loaded_d;
      ov_q     <= ov_d;
      iter_q   <= iter_d;
      k_q      <= k_d;
      tself_q  <= tself_d;
    end
  end

  always_ff @(posedge clk_i) begin
    flip_q <= flip_d;  cx_q <= cx_d;  cy_q <= cy_d;  cz_q <= cz_d;
    cos_q <= cos_d;  sin_q <= sin_d;  px_q <= px_d;  py_q <= py_d;
    prod_q <= prod_d;  acc_q <= acc_d;
    idx_q <= idx_d;  range_q <= range_d;  fin_q <= fin_d;  hit_q <= hit_d;
    o_idx_q <= o_idx_d;  o_range_q <= o_range_d;  o_fin_q <= o_fin_d;  o_hit_q <= o_hit_d;
    if (state_q == ST_IDLE && s_axis_tvalid_i && s_axis_tuser_i == FUNC_LOAD &&
        32'(in_slot) < OTHER_SLOTS) begin
      rob_x_q[SLOT_W'(in_slot)] <= in_x;
      rob_y_q[SLOT_W'(in_slot)] <= in_y;
    end
  end

  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = OUT_W'({o_fin_q, o_range_q, o_idx_q});
  assign m_axis_tuser_o  = o_hit_q;

endmodule
`default_nettype wire

/* hw/rtl/lcmf_checker.sv */
// Port-level checker for the lidar circle mask filter, bound to its top level.
// Depends on lcmf_pkg for the item and hit codes.
`default_nettype none
module lcmf_checker
  import lcmf_pkg::*;
#(
  parameter int OUT_W   = 32,
  parameter int FIN_BIT = 28
) (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             s_axis_tvalid_i,
  input wire logic             s_axis_tready_o,
  input wire logic [1:0]       s_axis_tuser_i,
  input wire logic             m_axis_tvalid_o,
  input wire logic             m_axis_tready_i,
  input wire logic [OUT_W-1:0] m_axis_tdata_o,
  input wire logic [1:0]       m_axis_tuser_o
);

  // A result that is not taken holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o)
      && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tuser_o == HIT_NONE || m_axis_tuser_o == HIT_SELF
      || m_axis_tuser_o == HIT_ROBOT)
    else $error("bad hit kind");

  // Only finite samples can be masked.
  a_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o != HIT_NONE |-> m_axis_tdata_o[FIN_BIT] == 1'b1)
    else $error("masked result not finite");

  // Start and load items finish in the cycle they are taken.
  a_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i != FUNC_SAMPLE |=> s_axis_tready_o)
    else $error("control item stalled the block");

endmodule

bind lidar_circle_mask_filter lcmf_checker #(
  .OUT_W  (((17+INDEX_BITS+7)/8)*8),
  .FIN_BIT(16+INDEX_BITS)
) u_lcmf_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tvalid_i(s_axis_tvalid_i),
  .s_axis_tready_o(s_axis_tready_o),
  .s_axis_tuser_i (s_axis_tuser_i),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o),
  .m_axis_tuser_o (m_axis_tuser_o)
);
`default_nettype wire
